// ===== sv/rsg_pkg.sv =====
package rsg_pkg;

  // Frame store geometry; both limits are powers of two, so the store address is
  // the row index over the column index
  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 128;
  localparam int SCOL_W     = $clog2(MAX_WIDTH);
  localparam int SROW_W     = $clog2(MAX_HEIGHT);
  localparam int ADDR_W     = SROW_W + SCOL_W;

  // Field widths
  localparam int COL_W   = 7;
  localparam int ROW_W   = 8;
  localparam int PIX_W   = 24;
  localparam int LANE_W  = 8;
  localparam int LANES   = 3;
  localparam int DIM_W   = 8;
  localparam int CFG_W   = 24;
  localparam int CIDX_W  = 2;

  // Fade weight arithmetic
  localparam int WEIGHT_SCALE = 1000;
  localparam int PER_W        = 10;
  localparam int NUM_W        = 16;
  localparam int DEN_W        = 7;
  localparam int ACC_W        = 18;
  localparam int RECIP_SHIFT  = 28;
  localparam int RECIP_W      = 19;
  localparam int PROD_W       = ACC_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'((2 ** RECIP_SHIFT + WEIGHT_SCALE - 1) / WEIGHT_SCALE);

  // Register indexes
  localparam logic [CIDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CIDX_W-1:0] REG_BG_COLOR     = 2'd2;

  // Opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef struct packed {
    logic             opcode;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
    logic [PIX_W-1:0] pixel_in;
  } req_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             out_of_range;
  } rsp_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_cmd_t;

  typedef struct packed {
    logic             start;
    logic [PER_W-1:0] per;
    logic [PIX_W-1:0] src;
    logic [PIX_W-1:0] bg;
  } blend_cmd_t;

endpackage

// ===== sv/rsg_frame_store.sv =====
module rsg_frame_store
  import rsg_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [PIX_W-1:0]  wdata,
  output logic [PIX_W-1:0]  rdata
);

  logic [PIX_W-1:0] mem [MAX_WIDTH*MAX_HEIGHT];

  // Write on enable, read registered every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== sv/rsg_weight_div.sv =====
module rsg_weight_div
  import rsg_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  div_cmd_t         cmd,
  output logic             done,
  output logic [PER_W-1:0] quot
);

  localparam int STEPS   = NUM_W / 2;
  localparam int CNT_W   = $clog2(STEPS);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [DEN_W-1:0]   den;
  logic [DEN_W-1:0]   rem;
  logic [NUM_W-1:0]   numsh;
  logic [NUM_W-1:0]   quo;
  logic [DEN_W-1:0]   rem_next;
  logic [NUM_W-1:0]   numsh_next;
  logic [NUM_W-1:0]   quo_next;

  // Two restoring steps per cycle
  always_comb begin
    logic [DEN_W:0] t;
    rem_next   = rem;
    numsh_next = numsh;
    quo_next   = quo;
    for (int i = 0; i < 2; i++) begin
      t          = {rem_next, numsh_next[NUM_W-1]};
      numsh_next = {numsh_next[NUM_W-2:0], 1'b0};
      if (t >= {1'b0, den}) begin
        t        = t - {1'b0, den};
        quo_next = {quo_next[NUM_W-2:0], 1'b1};
      end else begin
        quo_next = {quo_next[NUM_W-2:0], 1'b0};
      end
      rem_next = t[DEN_W-1:0];
    end
  end

  // Control: load on start, count down, flag completion
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (cmd.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNT_W'(STEPS - 1);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      den   <= cmd.den;
      rem   <= '0;
      numsh <= cmd.num;
      quo   <= '0;
    end else if (busy) begin
      rem   <= rem_next;
      numsh <= numsh_next;
      quo   <= quo_next;
    end
  end

  assign quot = quo[PER_W-1:0];

endmodule

// ===== sv/rsg_blend.sv =====
module rsg_blend
  import rsg_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  blend_cmd_t       cmd,
  output logic             done,
  output logic [PIX_W-1:0] pixel
);

  logic             busy;
  logic             phase;
  logic [1:0]       lane;
  logic [PER_W-1:0] per;
  logic [PER_W-1:0] inv;
  logic [PIX_W-1:0] src;
  logic [PIX_W-1:0] bg;
  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] acc_next;
  logic [PROD_W-1:0] prod;

  // Weighted sum of one lane, then divide by the scale through a reciprocal
  always_comb begin
    acc_next = ACC_W'(per) * ACC_W'(src[LANE_W*lane +: LANE_W])
             + ACC_W'(inv) * ACC_W'(bg[LANE_W*lane +: LANE_W]);
    prod     = PROD_W'(acc) * PROD_W'(RECIP);
  end

  // Control: alternate sum and scale phases over the three lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= 1'b0;
      lane  <= '0;
    end else if (cmd.start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      phase <= 1'b0;
      lane  <= '0;
    end else if (busy) begin
      phase <= ~phase;
      if (phase) begin
        lane <= lane + 1'b1;
        if (lane == 2'(LANES - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      per <= cmd.per;
      inv <= PER_W'(WEIGHT_SCALE) - cmd.per;
      src <= cmd.src;
      bg  <= cmd.bg;
    end else if (busy) begin
      if (!phase) begin
        acc <= acc_next;
      end else begin
        pixel[LANE_W*lane +: LANE_W] <= prod[RECIP_SHIFT +: LANE_W];
      end
    end
  end

endmodule

// ===== sv/reflection_shadow_generator.sv =====
// Flow: a read outside the image goes from decode straight to the output state, a copied or
// half-blend read first reads the store, and a faded shadow read also runs the 2-bit-per-cycle
// weight divider and then the blend multiplier, which alternates sum and scale over each color lane.
// Throughput: one request at a time; the output state waits while the held response is stalled.
// Reset: rst is synchronous, active high; it idles the control and restores the
// registers to width 128, height 128 and a black background; the store is kept.
module reflection_shadow_generator
  import rsg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              req_valid,
  output logic              req_stall,
  input  req_t              req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output rsp_t              rsp
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_COPY   = 3'd2;
  localparam logic [2:0] S_FETCH  = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_BLEND  = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [2:0]        state;
  logic [2:0]        state_next;
  req_t              req_q;
  logic [DIM_W-1:0]  image_width;
  logic [DIM_W-1:0]  image_height;
  logic [PIX_W-1:0]  background_color;
  logic              half_q;
  logic [PIX_W-1:0]  res_q;
  logic              flag_q;

  logic [DIM_W-1:0]  w_eff;
  logic [DIM_W-1:0]  h_eff;
  logic [DIM_W-1:0]  sh;
  logic [DIM_W:0]    row_limit;
  logic [DIM_W-1:0]  d;
  logic [DIM_W-1:0]  srow;
  logic [DIM_W-1:0]  span;
  logic              col_ok;
  logic              is_shadow_half;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [PIX_W-1:0]  mem_rdata;

  div_cmd_t          div_cmd;
  logic              div_done;
  logic [PER_W-1:0]  div_quot;
  blend_cmd_t        blend_cmd;
  logic              blend_done;
  logic [PIX_W-1:0]  blend_pixel;

  // Half and half blend of the upper shadow rows
  function automatic logic [PIX_W-1:0] half_blend(input logic [PIX_W-1:0] s,
                                                  input logic [PIX_W-1:0] b);
    logic [LANE_W:0] g;
    logic [LANE_W:0] r;
    logic [LANE_W-1:0] lo;
    lo = {1'b0, s[LANE_W-1:1]} + {1'b0, b[LANE_W-1:1]};
    g  = {1'b0, s[LANE_W +: LANE_W]} + {1'b0, b[LANE_W +: LANE_W]};
    r  = {1'b0, s[2*LANE_W +: LANE_W]} + {1'b0, b[2*LANE_W +: LANE_W]};
    return {r[LANE_W:1], g[LANE_W:1], lo};
  endfunction

  // Clamp the configured size to the store, then derive the shadow rows and bounds
  always_comb begin
    w_eff = (image_width > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : image_width;
    h_eff = (image_height > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : image_height;
    sh        = {1'b0, h_eff[DIM_W-1:1]};
    row_limit = {1'b0, h_eff} + {1'b0, sh};
    d         = req_q.row - h_eff;
    srow      = h_eff - 8'd1 - d;
    span      = sh - 8'd1 - d;
    col_ok    = {1'b0, req_q.column} < w_eff;
    is_shadow_half = d < {1'b0, sh[DIM_W-1:1]};
  end

  // Decode the held request; writes and reads never overlap, so no forwarding
  always_comb begin
    state_next      = state;
    mem_we          = 1'b0;
    mem_addr        = {req_q.row[SROW_W-1:0], req_q.column[SCOL_W-1:0]};
    div_cmd.start   = 1'b0;
    div_cmd.num     = NUM_W'(span) * NUM_W'(WEIGHT_SCALE);
    div_cmd.den     = sh[DEN_W-1:0];
    blend_cmd.start = 1'b0;
    blend_cmd.per   = div_quot;
    blend_cmd.src   = res_q;
    blend_cmd.bg    = background_color;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (req_q.opcode == OP_WRITE) begin
          mem_we     = col_ok && (req_q.row < h_eff);
          state_next = S_IDLE;
        end else if (!col_ok || ({1'b0, req_q.row} >= row_limit)) begin
          state_next = S_OUT;
        end else if (req_q.row < h_eff) begin
          state_next = S_COPY;
        end else begin
          mem_addr      = {srow[SROW_W-1:0], req_q.column[SCOL_W-1:0]};
          div_cmd.start = !is_shadow_half;
          state_next    = S_FETCH;
        end
      end
      S_COPY: begin
        state_next = S_OUT;
      end
      S_FETCH: begin
        state_next = half_q ? S_OUT : S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          blend_cmd.start = 1'b1;
          state_next      = S_BLEND;
        end
      end
      S_BLEND: begin
        if (blend_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!rsp_valid || !rsp_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign req_stall = (state != S_IDLE);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width      <= DIM_W'(128);
      image_height     <= DIM_W'(128);
      background_color <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width      <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT: image_height     <= cfg_data[DIM_W-1:0];
        REG_BG_COLOR:     background_color <= cfg_data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_OUT && (!rsp_valid || !rsp_stall)) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      req_q <= req;
    end
    unique case (state)
      S_DECODE: begin
        res_q  <= '0;
        flag_q <= !col_ok || ({1'b0, req_q.row} >= row_limit);
        half_q <= is_shadow_half;
      end
      S_COPY: begin
        res_q <= mem_rdata;
      end
      S_FETCH: begin
        res_q <= half_q ? half_blend(mem_rdata, background_color) : mem_rdata;
      end
      S_BLEND: begin
        if (blend_done) begin
          res_q <= blend_pixel;
        end
      end
      default: ;
    endcase
    if (state == S_OUT && (!rsp_valid || !rsp_stall)) begin
      rsp.pixel_out    <= res_q;
      rsp.out_of_range <= flag_q;
    end
  end

  rsg_frame_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (req_q.pixel_in),
    .rdata (mem_rdata)
  );

  rsg_weight_div u_div (
    .clk  (clk),
    .rst  (rst),
    .cmd  (div_cmd),
    .done (div_done),
    .quot (div_quot)
  );

  rsg_blend u_blend (
    .clk   (clk),
    .rst   (rst),
    .cmd   (blend_cmd),
    .done  (blend_done),
    .pixel (blend_pixel)
  );

endmodule
